[hdl/pair_spring_gravity_force_unit_macros.svh]
// Assertion macros shared by the pair force unit modules.
`ifndef PAIR_SPRING_GRAVITY_FORCE_UNIT_MACROS_SVH
`define PAIR_SPRING_GRAVITY_FORCE_UNIT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define PSGF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked only in cycles where the condition holds.
`define PSGF_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

`endif

[hdl/psgf_pkg.sv]
// Types, constants and helpers shared by the pair force unit.
package psgf_pkg;

	localparam int NUM_AXES = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 32;
	localparam int FORCE_W = 48;
	localparam int PROD_W = 94;

	localparam logic [CFG_IDX_W-1:0] CFG_SPRING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd1;

	localparam logic [CFG_W-1:0] CFG_RESET_ONE = 32'h0001_0000;
	// 0.1 in Q.15, rounded
	localparam logic [31:0] TENTH_Q15 = 32'd3277;

	localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [FORCE_W-1:0] FORCE_NEG_MIN = 48'h8000_0000_0000;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SPRING,
		KIND_GRAVITY,
		KIND_RESERVED
	} kind_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_SPRING,
		MODE_GRAVITY
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic zero;
		logic [NUM_AXES-1:0] neg;
		logic [NUM_AXES-1:0][FORCE_W-1:0] spr_force;
		logic spr_sat;
		logic [PROD_W-1:0] prod;
		logic [NUM_AXES-1:0][31:0] mag;
	} ctl_t;

	typedef struct packed {
		logic [63:0] q;
		ctl_t ctl;
	} usd_t;

	typedef struct packed {
		logic [NUM_AXES-1:0] huge;
		ctl_t ctl;
	} fsd_t;

	typedef struct packed {
		logic sat;
		logic [FORCE_W-1:0] val;
	} enc_t;

	// Clip a magnitude to the signed output range and apply the sign.
	function automatic enc_t encode(input logic [FORCE_W-1:0] mag, input logic neg,
			input logic huge);
		enc_t r;
		logic [FORCE_W-1:0] lim;
		logic [FORCE_W-1:0] m;
		lim = neg ? FORCE_NEG_MIN : FORCE_POS_MAX;
		m = mag;
		r.sat = 1'b0;
		if (huge || (mag > lim)) begin
			m = lim;
			r.sat = 1'b1;
		end
		r.val = neg ? (FORCE_W'(0) - m) : m;
		return r;
	endfunction

endpackage

[hdl/pair_spring_gravity_force_unit.sv]
// Top level: pair force unit, spring and softened gravity over a deep pipeline.
// Throughput: one item per cycle; busy stays low and start is taken every cycle.
// The pipeline length is set by the 32-stage square root and the 32- and 48-stage dividers.
// Results cannot be stalled; each appears for one cycle with done high.
// Reset clears all valid bits and sets both constants to 1.0.
`include "pair_spring_gravity_force_unit_macros.svh"
module pair_spring_gravity_force_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               wr_en,
	input  logic [psgf_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [psgf_pkg::CFG_W-1:0]         wr_data,
	input  logic [1:0]                         kind_first,
	input  logic [1:0]                         kind_second,
	input  logic signed [31:0]                 first_pos_x,
	input  logic signed [31:0]                 first_pos_y,
	input  logic signed [31:0]                 first_pos_z,
	input  logic signed [31:0]                 second_pos_x,
	input  logic signed [31:0]                 second_pos_y,
	input  logic signed [31:0]                 second_pos_z,
	input  logic [31:0]                        first_mass,
	input  logic [31:0]                        second_mass,
	output logic                               done,
	output logic signed [47:0]                 force_x,
	output logic signed [47:0]                 force_y,
	output logic signed [47:0]                 force_z,
	output logic                               zero_separation,
	output logic                               saturated
);

	localparam int NA = psgf_pkg::NUM_AXES;
	localparam int FW = psgf_pkg::FORCE_W;

	logic [31:0] spring_k_q;
	logic [31:0] grav_g_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_k_q <= psgf_pkg::CFG_RESET_ONE;
			grav_g_q <= psgf_pkg::CFG_RESET_ONE;
		end else if (wr_en) begin
			if (wr_index == psgf_pkg::CFG_SPRING) begin
				spring_k_q <= wr_data;
			end
			if (wr_index == psgf_pkg::CFG_GRAVITY) begin
				grav_g_q <= wr_data;
			end
		end
	end

	// ---- stage 1: separation, magnitude, sign, pair type ----
	logic [NA-1:0][31:0] p1, p2, mag_c;
	logic [NA-1:0]       neg_c;
	psgf_pkg::mode_t     mode_c;

	assign p1 = {first_pos_z, first_pos_y, first_pos_x};
	assign p2 = {second_pos_z, second_pos_y, second_pos_x};

	always_comb begin
		logic [32:0] d;
		logic [32:0] ad;
		for (int i = 0; i < NA; i++) begin
			d = {p2[i][31], p2[i]} - {p1[i][31], p1[i]};
			neg_c[i] = d[32];
			ad = d[32] ? (33'd0 - d) : d;
			mag_c[i] = ad[31:0];
		end
		mode_c = psgf_pkg::MODE_NONE;
		if (kind_first == kind_second) begin
			case (psgf_pkg::kind_t'(kind_first))
				psgf_pkg::KIND_SPRING:  mode_c = psgf_pkg::MODE_SPRING;
				psgf_pkg::KIND_GRAVITY: mode_c = psgf_pkg::MODE_GRAVITY;
				default:                mode_c = psgf_pkg::MODE_NONE;
			endcase
		end
	end

	logic                valid_s1;
	psgf_pkg::mode_t     mode_s1;
	logic [NA-1:0]       neg_s1;
	logic [NA-1:0][31:0] mag_s1;
	logic [31:0]         m1_s1, m2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_c;
		neg_s1 <= neg_c;
		mag_s1 <= mag_c;
		m1_s1 <= first_mass;
		m2_s1 <= second_mass;
	end

	// ---- stage 2: spring products, squares, G*m1 ----
	logic                valid_s2;
	psgf_pkg::mode_t     mode_s2;
	logic [NA-1:0]       neg_s2;
	logic [NA-1:0][31:0] mag_s2;
	logic [NA-1:0][63:0] spr_s2;
	logic [NA-1:0][61:0] sq_s2;
	logic [63:0]         gm1_s2;
	logic [31:0]         m2_s2;
	logic                zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] sq;
		for (int i = 0; i < NA; i++) begin
			spr_s2[i] <= 64'(mag_s1[i]) * 64'(spring_k_q);
			sq = 64'(mag_s1[i]) * 64'(mag_s1[i]);
			sq_s2[i] <= sq[63:2];
		end
		gm1_s2 <= 64'(grav_g_q) * 64'(m1_s1);
		m2_s2 <= m2_s1;
		mode_s2 <= mode_s1;
		neg_s2 <= neg_s1;
		mag_s2 <= mag_s1;
		zero_s2 <= (mag_s1[0] | mag_s1[1] | mag_s1[2]) == 32'd0;
	end

	// ---- stage 3: spring encode, length squared, mass product halves ----
	logic                   valid_s3;
	psgf_pkg::mode_t        mode_s3;
	logic [NA-1:0]          neg_s3;
	logic [NA-1:0][31:0]    mag_s3;
	logic [NA-1:0][FW-1:0]  spr_force_s3;
	logic                   spr_sat_s3;
	logic [63:0]            s_s3;
	logic [63:0]            pl_s3, ph_s3;
	logic                   zero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		psgf_pkg::enc_t e;
		logic sat;
		sat = 1'b0;
		for (int i = 0; i < NA; i++) begin
			e = psgf_pkg::encode(spr_s2[i][63:16], neg_s2[i], 1'b0);
			spr_force_s3[i] <= e.val;
			sat = sat | e.sat;
		end
		spr_sat_s3 <= sat;
		s_s3 <= 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);
		pl_s3 <= 64'(gm1_s2[31:0]) * 64'(m2_s2);
		ph_s3 <= 64'(gm1_s2[63:32]) * 64'(m2_s2);
		mode_s3 <= mode_s2;
		neg_s3 <= neg_s2;
		mag_s3 <= mag_s2;
		zero_s3 <= zero_s2;
	end

	// ---- square root of the length squared ----
	logic [95:0]     gmm;
	psgf_pkg::ctl_t  ctl_in;
	psgf_pkg::ctl_t  ctl_sq;
	logic            sq_valid;
	logic [31:0]     root;

	assign gmm = {ph_s3, 32'd0} + {32'd0, pl_s3};

	always_comb begin
		ctl_in.mode = mode_s3;
		ctl_in.zero = zero_s3;
		ctl_in.neg = neg_s3;
		ctl_in.spr_force = spr_force_s3;
		ctl_in.spr_sat = spr_sat_s3;
		ctl_in.prod = gmm[95:2];
		ctl_in.mag = mag_s3;
	end

	psgf_sqrt #(
		.PW($bits(psgf_pkg::ctl_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.x_in     (s_s3),
		.side_in  (ctl_in),
		.out_valid(sq_valid),
		.root     (root),
		.side_out (ctl_sq)
	);

	// ---- stage 5: clamp length, add softening ----
	logic           valid_s5;
	logic [31:0]    lr_s5, er_s5;
	psgf_pkg::ctl_t ctl_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] lr;
		lr = (root == 32'd0) ? 32'd1 : root;
		lr_s5 <= lr;
		er_s5 <= lr + psgf_pkg::TENTH_Q15;
		ctl_s5 <= ctl_sq;
	end

	// ---- stage 6: squared softened length ----
	logic           valid_s6;
	logic [31:0]    lr_s6;
	logic [63:0]    q_s6;
	psgf_pkg::ctl_t ctl_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		q_s6 <= 64'(er_s5) * 64'(er_s5);
		lr_s6 <= lr_s5;
		ctl_s6 <= ctl_s5;
	end

	// ---- unit vector: mag * 2^29 / length ----
	logic [NA-1:0][31:0] u_rem_in, u_num_in, u_quo;
	psgf_pkg::usd_t      u_side_in, u_side_out;
	logic                u_valid;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			// the quotient stays below 2^32, so the top of the numerator starts as remainder
			u_rem_in[i] = {3'd0, ctl_s6.mag[i][31:3]};
			u_num_in[i] = {ctl_s6.mag[i][2:0], 29'd0};
		end
		u_side_in.q = q_s6;
		u_side_in.ctl = ctl_s6;
	end

	psgf_div #(
		.QW(32),
		.DW(32),
		.PW($bits(psgf_pkg::usd_t))
	) u_unit_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s6),
		.rem_in   (u_rem_in),
		.num_in   (u_num_in),
		.den_in   (lr_s6),
		.side_in  (u_side_in),
		.out_valid(u_valid),
		.quo      (u_quo),
		.side_out (u_side_out)
	);

	// ---- stage 7: partial products of P * u ----
	logic                     valid_s7;
	logic [NA-1:0][2:0][63:0] mm_s7;
	logic [63:0]              q_s7;
	psgf_pkg::ctl_t           ctl_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= u_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			mm_s7[i][0] <= 64'(u_quo[i]) * 64'(u_side_out.ctl.prod[31:0]);
			mm_s7[i][1] <= 64'(u_quo[i]) * 64'(u_side_out.ctl.prod[63:32]);
			mm_s7[i][2] <= 64'(u_quo[i]) * 64'({2'b00, u_side_out.ctl.prod[93:64]});
		end
		q_s7 <= u_side_out.q;
		ctl_s7 <= u_side_out.ctl;
	end

	// ---- stage 8: sum partial products ----
	logic                 valid_s8;
	logic [NA-1:0][125:0] n_s8;
	logic [63:0]          q_s8;
	psgf_pkg::ctl_t       ctl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic [127:0] sum;
		for (int i = 0; i < NA; i++) begin
			sum = {64'd0, mm_s7[i][0]} + {32'd0, mm_s7[i][1], 32'd0} + {mm_s7[i][2], 64'd0};
			n_s8[i] <= sum[125:0];
		end
		q_s8 <= q_s7;
		ctl_s8 <= ctl_s7;
	end

	// ---- stage 9: overflow check ahead of the force divider ----
	logic                 valid_s9;
	logic [NA-1:0][125:0] n_s9;
	logic [NA-1:0]        huge_s9;
	logic [63:0]          q_s9;
	psgf_pkg::ctl_t       ctl_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			huge_s9[i] <= {16'd0, n_s8[i][125:78]} >= q_s8;
		end
		n_s9 <= n_s8;
		q_s9 <= q_s8;
		ctl_s9 <= ctl_s8;
	end

	// ---- force magnitude: floor(N / q) >> 30, top quotient bits only ----
	logic [NA-1:0][63:0] f_rem_in;
	logic [NA-1:0][FW-1:0] f_num_in, f_quo;
	psgf_pkg::fsd_t      f_side_in, f_side_out;
	logic                f_valid;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			// drop the start remainder when the quotient would overflow
			f_rem_in[i] = huge_s9[i] ? 64'd0 : {16'd0, n_s9[i][125:78]};
			f_num_in[i] = n_s9[i][77:30];
		end
		f_side_in.huge = huge_s9;
		f_side_in.ctl = ctl_s9;
	end

	psgf_div #(
		.QW(FW),
		.DW(64),
		.PW($bits(psgf_pkg::fsd_t))
	) u_force_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s9),
		.rem_in   (f_rem_in),
		.num_in   (f_num_in),
		.den_in   (q_s9),
		.side_in  (f_side_in),
		.out_valid(f_valid),
		.quo      (f_quo),
		.side_out (f_side_out)
	);

	// ---- output stage: select by pair type, encode, register ----
	logic [NA-1:0][FW-1:0] force_c;
	logic                  sat_c, zero_c;

	always_comb begin
		psgf_pkg::enc_t e;
		e = '0;
		force_c = '0;
		sat_c = 1'b0;
		zero_c = 1'b0;
		case (f_side_out.ctl.mode)
			psgf_pkg::MODE_SPRING: begin
				force_c = f_side_out.ctl.spr_force;
				sat_c = f_side_out.ctl.spr_sat;
			end
			psgf_pkg::MODE_GRAVITY: begin
				if (f_side_out.ctl.zero) begin
					zero_c = 1'b1;
				end else begin
					for (int i = 0; i < NA; i++) begin
						e = psgf_pkg::encode(f_quo[i], f_side_out.ctl.neg[i],
							f_side_out.huge[i]);
						force_c[i] = e.val;
						sat_c = sat_c | e.sat;
					end
				end
			end
			default: begin
				force_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= f_valid;
		end
	end

	always_ff @(posedge clk) begin
		force_x <= force_c[0];
		force_y <= force_c[1];
		force_z <= force_c[2];
		zero_separation <= zero_c;
		saturated <= sat_c;
	end

	`PSGF_ASSERT_IMP(a_zero_sep_clean, done && zero_separation, (force_x == 48'sd0) && (force_y == 48'sd0) && (force_z == 48'sd0) && !saturated, "coincident pair gave a force or a clip")
	`PSGF_ASSERT_IMP(a_sat_at_limit, done && saturated, (force_x == psgf_pkg::FORCE_POS_MAX) || (force_x == psgf_pkg::FORCE_NEG_MIN) || (force_y == psgf_pkg::FORCE_POS_MAX) || (force_y == psgf_pkg::FORCE_NEG_MIN) || (force_z == psgf_pkg::FORCE_POS_MAX) || (force_z == psgf_pkg::FORCE_NEG_MIN), "clip flag without a limit value")

endmodule

[hdl/psgf_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`include "pair_spring_gravity_force_unit_macros.svh"
module psgf_sqrt #(
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [63:0]   x_in,
	input  logic [PW-1:0] side_in,
	output logic          out_valid,
	output logic [31:0]   root,
	output logic [PW-1:0] side_out
);

	localparam int RW = 32;

	logic          valid_s [1:RW];
	logic [63:0]   rem_s   [1:RW];
	logic [RW-1:0] root_s  [1:RW];
	logic [PW-1:0] side_s  [1:RW];

	genvar g;
	for (g = 0; g < RW; g++) begin : g_stage
		localparam int K = RW - 1 - g;
		logic          cur_valid;
		logic [63:0]   cur_rem;
		logic [RW-1:0] cur_root;
		logic [PW-1:0] cur_side;
		logic [65:0]   trial;
		logic          take;

		if (g == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_rem = x_in;
			assign cur_root = '0;
			assign cur_side = side_in;
		end else begin : g_rest
			assign cur_valid = valid_s[g];
			assign cur_rem = rem_s[g];
			assign cur_root = root_s[g];
			assign cur_side = side_s[g];
		end

		// root bits sit above K, so the two terms do not overlap
		assign trial = ({34'd0, cur_root} << (K + 1)) | (66'd1 << (2 * K));
		assign take = {2'b00, cur_rem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= take ? 64'({2'b00, cur_rem} - trial) : cur_rem;
			root_s[g+1] <= take ? (cur_root | (RW'(1) << K)) : cur_root;
			side_s[g+1] <= cur_side;
		end
	end

	assign out_valid = valid_s[RW];
	assign root = root_s[RW];
	assign side_out = side_s[RW];

	`PSGF_ASSERT_IMP(a_sqrt_rem_bound, out_valid, rem_s[RW] <= {31'd0, root_s[RW], 1'b0}, "square root remainder exceeds twice the root")

endmodule

[hdl/psgf_div.sv]
// Pipelined restoring divider, three lanes over a shared divisor.
`include "pair_spring_gravity_force_unit_macros.svh"
module psgf_div #(
	parameter int QW = 32,
	parameter int DW = 32,
	parameter int PW = 1
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	input  logic [psgf_pkg::NUM_AXES-1:0][DW-1:0]      rem_in,
	input  logic [psgf_pkg::NUM_AXES-1:0][QW-1:0]      num_in,
	input  logic [DW-1:0]                              den_in,
	input  logic [PW-1:0]                              side_in,
	output logic                                       out_valid,
	output logic [psgf_pkg::NUM_AXES-1:0][QW-1:0]      quo,
	output logic [PW-1:0]                              side_out
);

	localparam int NA = psgf_pkg::NUM_AXES;

	logic                     valid_s [1:QW];
	logic [NA-1:0][DW-1:0]    rem_s   [1:QW];
	logic [NA-1:0][QW-1:0]    nq_s    [1:QW];
	logic [DW-1:0]            den_s   [1:QW];
	logic [PW-1:0]            side_s  [1:QW];

	genvar g, l;
	for (g = 0; g < QW; g++) begin : g_stage
		logic                  cur_valid;
		logic [NA-1:0][DW-1:0] cur_rem;
		logic [NA-1:0][QW-1:0] cur_nq;
		logic [DW-1:0]         cur_den;
		logic [PW-1:0]         cur_side;
		logic [NA-1:0][DW-1:0] next_rem;
		logic [NA-1:0][QW-1:0] next_nq;

		if (g == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_rem = rem_in;
			assign cur_nq = num_in;
			assign cur_den = den_in;
			assign cur_side = side_in;
		end else begin : g_rest
			assign cur_valid = valid_s[g];
			assign cur_rem = rem_s[g];
			assign cur_nq = nq_s[g];
			assign cur_den = den_s[g];
			assign cur_side = side_s[g];
		end

		for (l = 0; l < NA; l++) begin : g_lane
			logic [DW:0] t;
			logic [DW:0] diff;
			logic        ge;
			// shift in the next numerator bit; the quotient bit fills the freed slot
			assign t = {cur_rem[l], cur_nq[l][QW-1]};
			assign diff = t - {1'b0, cur_den};
			assign ge = t >= {1'b0, cur_den};
			assign next_rem[l] = ge ? diff[DW-1:0] : t[DW-1:0];
			assign next_nq[l] = {cur_nq[l][QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= next_rem;
			nq_s[g+1] <= next_nq;
			den_s[g+1] <= cur_den;
			side_s[g+1] <= cur_side;
		end
	end

	assign out_valid = valid_s[QW];
	assign quo = nq_s[QW];
	assign side_out = side_s[QW];

	`PSGF_ASSERT_IMP(a_div_rem_lt_den, out_valid, (rem_s[QW][0] < den_s[QW]) && (rem_s[QW][1] < den_s[QW]) && (rem_s[QW][2] < den_s[QW]), "divider remainder not below divisor")

endmodule

[bench/pair_force_checker.sv]
// Checker for the pair force unit: predicts each force item and compares the results.
module pair_force_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           wr_en,
	input  logic [psgf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [psgf_pkg::CFG_W-1:0]     wr_data,
	input  logic [1:0]                     kind_first,
	input  logic [1:0]                     kind_second,
	input  logic [31:0]                    first_pos_x,
	input  logic [31:0]                    first_pos_y,
	input  logic [31:0]                    first_pos_z,
	input  logic [31:0]                    second_pos_x,
	input  logic [31:0]                    second_pos_y,
	input  logic [31:0]                    second_pos_z,
	input  logic [31:0]                    first_mass,
	input  logic [31:0]                    second_mass,
	input  logic                           done,
	input  logic [47:0]                    force_x,
	input  logic [47:0]                    force_y,
	input  logic [47:0]                    force_z,
	input  logic                           zero_separation,
	input  logic                           saturated,
	output int                             errors,
	output int                             pending,
	output int                             forces_seen,
	output int                             sat_seen,
	output int                             coincident_seen
);
	import psgf_pkg::*;

	typedef struct {
		logic [47:0] fx;
		logic [47:0] fy;
		logic [47:0] fz;
		logic        zero;
		logic        sat;
	} force_t;

	force_t expected_forces[$];
	logic [31:0] stiffness;
	logic [31:0] grav_const;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Clip a magnitude to the Q32.16 range and apply the sign.
	function automatic logic [47:0] clip_force(input logic [63:0] mag, input logic neg,
			input logic huge, inout logic sat);
		logic [63:0] lim;
		lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
		if (huge || mag > lim) begin
			mag = lim;
			sat = 1'b1;
		end
		return neg ? 48'(64'd0 - mag) : mag[47:0];
	endfunction

	function automatic force_t pair_force(input logic [1:0] k1, input logic [1:0] k2,
			input logic [31:0] p1 [3], input logic [31:0] p2 [3],
			input logic [31:0] m1, input logic [31:0] m2);
		force_t r;
		logic signed [33:0] d;
		logic [63:0] a [3];
		logic neg [3];
		logic [47:0] f [3];
		logic [63:0] s, lr, er, q, u;
		logic [127:0] p, w;
		logic sat;
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d = $signed({{2{p2[i][31]}}, p2[i]}) - $signed({{2{p1[i][31]}}, p1[i]});
			neg[i] = d[33];
			a[i] = neg[i] ? 64'(-d) : 64'(d);
			f[i] = '0;
		end
		r.zero = 1'b0;
		if (k1 == k2 && kind_t'(k1) == KIND_SPRING) begin
			for (int i = 0; i < 3; i++)
				f[i] = clip_force((a[i] * stiffness) >> 16, neg[i], 1'b0, sat);
		end else if (k1 == k2 && kind_t'(k1) == KIND_GRAVITY) begin
			if ((a[0] | a[1] | a[2]) == 0) begin
				r.zero = 1'b1;
			end else begin
				s = ((a[0] * a[0]) >> 2) + ((a[1] * a[1]) >> 2) + ((a[2] * a[2]) >> 2);
				lr = floor_sqrt(s);
				if (lr == 0) lr = 1;
				er = lr + 64'(TENTH_Q15);
				q = er * er;
				p = (128'(grav_const) * 128'(m1) * 128'(m2)) >> 2;
				for (int i = 0; i < 3; i++) begin
					u = (a[i] << 29) / lr;
					w = (p * 128'(u)) / 128'(q);
					f[i] = clip_force(w[93:30], neg[i], (w >> 94) != 0, sat);
				end
			end
		end
		r.fx = f[0];
		r.fy = f[1];
		r.fz = f[2];
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	assign pending = expected_forces.size();

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] p1 [3];
		logic [31:0] p2 [3];
		force_t w;
		if (!arst_n) begin
			stiffness <= CFG_RESET_ONE;
			grav_const <= CFG_RESET_ONE;
			expected_forces.delete();
		end else begin
			if (wr_en) begin
				if (wr_index == CFG_SPRING) stiffness <= wr_data;
				else if (wr_index == CFG_GRAVITY) grav_const <= wr_data;
			end
			if (start && !busy) begin
				p1 = '{first_pos_x, first_pos_y, first_pos_z};
				p2 = '{second_pos_x, second_pos_y, second_pos_z};
				expected_forces.push_back(pair_force(kind_first, kind_second, p1, p2,
					first_mass, second_mass));
			end
			if (done) begin
				forces_seen++;
				if (saturated) sat_seen++;
				if (zero_separation) coincident_seen++;
				if (expected_forces.size() == 0) begin
					report_mismatch("unexpected item", 48'd0, 48'd0);
				end else begin
					w = expected_forces.pop_front();
					if (force_x !== w.fx) report_mismatch("force_x", force_x, w.fx);
					if (force_y !== w.fy) report_mismatch("force_y", force_y, w.fy);
					if (force_z !== w.fz) report_mismatch("force_z", force_z, w.fz);
					if (zero_separation !== w.zero)
						report_mismatch("zero_separation", 48'(zero_separation), 48'(w.zero));
					if (saturated !== w.sat)
						report_mismatch("saturated", 48'(saturated), 48'(w.sat));
				end
			end
		end
	end

	initial begin
		errors = 0;
		forces_seen = 0;
		sat_seen = 0;
		coincident_seen = 0;
	end
endmodule

[bench/pair_spring_gravity_force_unit_tb.sv]
// Testbench top: drives pair items and register writes, and gives the verdict.
module pair_spring_gravity_force_unit_tb;
	import psgf_pkg::*;

	localparam int DRAIN_CYCLES = 140;
	localparam int STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = CFG_SPRING;
	logic [CFG_W-1:0] wr_data = '0;
	logic [1:0] kind_first = KIND_NONE;
	logic [1:0] kind_second = KIND_NONE;
	logic [31:0] first_pos_x = '0, first_pos_y = '0, first_pos_z = '0;
	logic [31:0] second_pos_x = '0, second_pos_y = '0, second_pos_z = '0;
	logic [31:0] first_mass = '0, second_mass = '0;
	logic done;
	logic [47:0] force_x, force_y, force_z;
	logic zero_separation, saturated;
	int errors, pending, forces_seen, sat_seen, coincident_seen;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit allow_idle = 1'b1;

	always #6 clk = ~clk;

	pair_spring_gravity_force_unit u_dut (.*);

	pair_force_checker u_chk (.*);

	// Watchdog: count cycles with no item moving either way.
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("[pair_spring_gravity_force_unit] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 32'h40_0000);
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom_range(0, 32'hFFFF);
		endcase
	endfunction

	task automatic send_pair(input logic [1:0] k1, input logic [1:0] k2,
			input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
			input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
			input logic [31:0] m1, input logic [31:0] m2);
		kind_first <= k1;
		kind_second <= k2;
		first_pos_x <= ax;
		first_pos_y <= ay;
		first_pos_z <= az;
		second_pos_x <= bx;
		second_pos_y <= by;
		second_pos_z <= bz;
		first_mass <= m1;
		second_mass <= m2;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		if (allow_idle && $urandom_range(0, 99) < 23) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic [1:0] k1, k2;
		logic [31:0] ax, ay, az, bx, by, bz;
		k1 = ($urandom_range(0, 9) < 8) ? ($urandom_range(0, 1) ? KIND_SPRING : KIND_GRAVITY)
			: 2'($urandom_range(0, 3));
		k2 = ($urandom_range(0, 9) < 8) ? k1 : 2'($urandom_range(0, 3));
		ax = rand_pos(); ay = rand_pos(); az = rand_pos();
		bx = rand_pos(); by = rand_pos(); bz = rand_pos();
		// Pull the second particle onto or near the first now and then.
		case ($urandom_range(0, 5))
			0: begin bx = ax; by = ay; bz = az; end
			1: begin
				bx = ax + 32'($signed($urandom_range(0, 6)) - 3);
				by = ay + 32'($signed($urandom_range(0, 6)) - 3);
				bz = az;
			end
			default: ;
		endcase
		send_pair(k1, k2, ax, ay, az, bx, by, bz, rand_mass(), rand_mass());
	endtask

	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset constants
		send_pair(KIND_SPRING, KIND_SPRING, 32'h8000_0000, 32'h7FFF_FFFF, 0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000, 0, 0);
		send_pair(KIND_SPRING, KIND_SPRING, 5, 5, 5, 5, 5, 5, 1, 1);
		send_pair(KIND_GRAVITY, KIND_GRAVITY, 7, 7, 7, 7, 7, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(KIND_GRAVITY, KIND_GRAVITY, 0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(KIND_GRAVITY, KIND_GRAVITY, 0, 0, 0, 32'h1_0000, 32'h2_0000, 32'hFFFE_0000,
			32'h1_0000, 32'h1_0000);
		send_pair(KIND_GRAVITY, KIND_GRAVITY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(KIND_GRAVITY, KIND_GRAVITY, 0, 0, 0, 32'h10_0000, 0, 0, 0, 32'hFFFF_FFFF);
		send_pair(KIND_SPRING, KIND_GRAVITY, 0, 0, 0, 32'h1_0000, 0, 0, 1, 1);
		send_pair(KIND_GRAVITY, KIND_SPRING, 0, 0, 0, 32'h1_0000, 0, 0, 1, 1);
		send_pair(KIND_NONE, KIND_NONE, 0, 0, 0, 32'h1_0000, 0, 0, 1, 1);
		send_pair(KIND_RESERVED, KIND_RESERVED, 0, 0, 0, 32'h1_0000, 0, 0, 1, 1);
		send_pair(KIND_NONE, KIND_SPRING, 0, 0, 0, 32'h1_0000, 0, 0, 1, 1);
		send_pair(KIND_RESERVED, KIND_GRAVITY, 0, 0, 0, 32'h1_0000, 0, 0, 1, 1);
		quiesce();

		write_reg(CFG_SPRING, 32'hFFFF_FFFF);
		write_reg(CFG_GRAVITY, 32'hFFFF_FFFF);
		send_pair(KIND_SPRING, KIND_SPRING, 32'h8000_0000, 0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1, 32'h8000_0000, 0, 0);
		send_pair(KIND_GRAVITY, KIND_GRAVITY, 0, 0, 0, 2, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 200; i++) send_random();
		quiesce();

		write_reg(CFG_SPRING, 32'h0);
		write_reg(CFG_GRAVITY, 32'h0);
		allow_idle = 1'b0;
		for (int i = 0; i < 200; i++) send_random();
		allow_idle = 1'b1;
		quiesce();

		for (int ph = 0; ph < 2; ph++) begin
			write_reg(CFG_SPRING, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0,
				32'h4_0000));
			write_reg(CFG_GRAVITY, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0,
				32'h4_0000));
			for (int i = 0; i < 230; i++) send_random();
			quiesce();
		end

		$display("covered %0d items and %0d results over five register settings", items_sent,
			forces_seen);
		$display("saturated results %0d, coincident gravity pairs %0d", sat_seen,
			coincident_seen);
		if (errors == 0) begin
			$display("[pair_spring_gravity_force_unit] OK");
		end else begin
			$display("[pair_spring_gravity_force_unit] ERROR");
		end
		$finish;
	end
endmodule
